[rtl/srt_pkg.sv]
// Shared types and constants for the sorted record table.
// Holds record layout, opcodes, status codes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package srt_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int HEAD_W  = 64;
    localparam int TAIL_W  = 8;
    localparam int AGE_W   = 8;
    localparam int PHONE_W = 31;
    localparam int TALLY_W = 6;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // Input tdata: key_head, key_tail, age, phone, padded to whole bytes
    localparam int IN_DATA_W  = 112;
    // Output tdata: rec_head, rec_tail, rec_age, rec_phone, tally, padded
    localparam int OUT_DATA_W = 120;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_RECORD = 2'd0,
        ST_INS_OK = 2'd1,
        ST_FULL   = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic [AGE_W-1:0]   age;
        logic [PHONE_W-1:0] phone;
    } t_rec;

    // Row-wide command from the controller to every cell
    typedef struct packed {
        logic ins;  // open a slot at the insert point and fill it
        logic del;  // pull the row left from the first matching cell
        logic rot;  // rotate the occupied cells left by one
    } t_cell_cmd;

endpackage

[rtl/srt_cell.sv]
// One cell of the sorted record row: a record, its valid bit and its key compare.
// Depends on srt_pkg for the record and command types.
`timescale 1ns / 1ps

module srt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srt_pkg::t_cell_cmd i_cmd,
    input  srt_pkg::t_rec      i_new_rec,
    input  srt_pkg::t_rec      i_prev_rec,
    input  logic               i_prev_valid,
    input  logic               i_prev_take,
    input  srt_pkg::t_rec      i_next_rec,
    input  logic               i_next_valid,
    input  srt_pkg::t_rec      i_first_rec,
    output srt_pkg::t_rec      o_rec,
    output logic               o_valid,
    output logic               o_take,
    output logic               o_eq
);
    import srt_pkg::*;

    t_rec r_rec;
    t_rec n_rec;
    logic r_valid;
    logic n_valid;
    logic w_ge;

    // Compare the held name with the operation key as one 72-bit value
    assign w_ge    = r_valid && (r_rec.key >= i_new_rec.key);
    assign o_eq    = r_valid && (r_rec.key == i_new_rec.key);
    assign o_take  = !r_valid || w_ge;
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    // Pick the next content: shift right, load new, shift left or rotate
    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (i_prev_take) begin
                n_rec   = i_prev_rec;
                n_valid = i_prev_valid;
            end else if (o_take) begin
                n_rec   = i_new_rec;
                n_valid = 1'b1;
            end
        end else if (i_cmd.del) begin
            if (o_take) begin
                n_rec   = i_next_rec;
                n_valid = i_next_valid;
            end
        end else if (i_cmd.rot) begin
            if (r_valid) begin
                n_rec = i_next_valid ? i_next_rec : i_first_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

[rtl/sorted_record_table.sv]
// Top level of the sorted record table: stream ports, controller and the cell row.
// Depends on srt_pkg and srt_cell.
`timescale 1ns / 1ps

// Sorted record table. Records live in a row of CAPACITY cells kept in
// ascending name order, occupied cells always at the front; reset empties the
// row at once, with no clearing pass. One transaction is handled at a time.
// Insert shifts the row right from the insert point in one step. Delete pulls
// the row left by one cell per cycle while any cell still matches. Search and
// list rotate the occupied cells past cell 0, one per cycle while the output
// register is free for each record due out, which leaves from cell 0, so the
// row is back in order when the final transaction goes out. Every operation
// ends with one transaction marked tlast that carries the count.
module sorted_record_table #(
    parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [63:0] key_head, [71:64] key_tail, [79:72] age_in, [110:80] phone_in
    input  logic [srt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [1:0] op
    input  logic [srt_pkg::OP_W-1:0]        i_s_tuser,
    // Master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [63:0] rec_head, [71:64] rec_tail, [79:72] rec_age, [110:80] rec_phone,
    // [116:111] tally
    output logic [srt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [srt_pkg::STAT_W-1:0]      o_m_tuser,
    output logic                            o_m_tlast
);
    import srt_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    // Controller state
    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;
    t_rec   r_new;
    t_rec   n_new;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_count;
    logic [FILL_W-1:0] n_count;
    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] n_idx;

    // Output register
    logic    r_m_tvalid;
    logic    n_m_tvalid;
    t_rec    r_out_rec;
    t_rec    n_out_rec;
    t_status r_out_stat;
    t_status n_out_stat;
    logic [TALLY_W-1:0] r_out_tally;
    logic [TALLY_W-1:0] n_out_tally;
    logic    r_out_last;
    logic    n_out_last;

    // Cell row wiring
    t_cell_cmd             w_cmd;
    t_rec                  w_rec [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_take;
    logic [CAPACITY-1:0]   w_eq;
    logic                  w_any_eq;
    logic                  w_out_free;
    logic                  w_hit;

    assign w_any_eq   = |w_eq;
    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_hit      = (r_op == OP_LIST) || w_eq[0];

    // Build the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec w_prev_rec;
        logic w_prev_valid;
        logic w_prev_take;
        t_rec w_next_rec;
        logic w_next_valid;

        if (g == 0) begin : g_first
            assign w_prev_rec   = r_new;
            assign w_prev_valid = 1'b0;
            assign w_prev_take  = 1'b0;
        end else begin : g_mid
            assign w_prev_rec   = w_rec[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_take  = w_take[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_rec   = w_rec[0];
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_rec   = w_rec[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        srt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_rec    (r_new),
            .i_prev_rec   (w_prev_rec),
            .i_prev_valid (w_prev_valid),
            .i_prev_take  (w_prev_take),
            .i_next_rec   (w_next_rec),
            .i_next_valid (w_next_valid),
            .i_first_rec  (w_rec[0]),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_take       (w_take[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Next state, row commands and output loads
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_new       = r_new;
        n_fill      = r_fill;
        n_count     = r_count;
        n_idx       = r_idx;
        n_m_tvalid  = r_m_tvalid && !i_m_tready;
        n_out_rec   = r_out_rec;
        n_out_stat  = r_out_stat;
        n_out_tally = r_out_tally;
        n_out_last  = r_out_last;
        w_cmd       = '0;
        o_s_tready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op        = t_op'(i_s_tuser);
                    n_new.key   = {i_s_tdata[63:0], i_s_tdata[71:64]};
                    n_new.age   = i_s_tdata[79:72];
                    n_new.phone = i_s_tdata[110:80];
                    n_count     = '0;
                    n_idx       = '0;
                    unique case (t_op'(i_s_tuser))
                        OP_INSERT: n_state = S_INS;
                        OP_DELETE: n_state = S_DEL;
                        OP_SEARCH,
                        OP_LIST:   n_state = S_SCAN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            // Insert in one step, or refuse when full
            S_INS: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_out_rec  = '0;
                    n_out_last = 1'b1;
                    if (r_fill == FILL_W'(CAPACITY)) begin
                        n_out_stat  = ST_FULL;
                        n_out_tally = TALLY_W'(r_fill);
                    end else begin
                        w_cmd.ins   = 1'b1;
                        n_fill      = r_fill + FILL_W'(1);
                        n_out_stat  = ST_INS_OK;
                        n_out_tally = TALLY_W'(r_fill + FILL_W'(1));
                    end
                    n_state = S_IDLE;
                end
            end

            // Drop one matching record per cycle until none is left
            S_DEL: begin
                if (w_any_eq) begin
                    w_cmd.del = 1'b1;
                    n_count   = r_count + FILL_W'(1);
                    n_fill    = r_fill - FILL_W'(1);
                end else if (w_out_free) begin
                    n_m_tvalid  = 1'b1;
                    n_out_rec   = '0;
                    n_out_stat  = ST_DONE;
                    n_out_tally = TALLY_W'(r_count);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // Rotate the row past cell 0, emitting what is due
            S_SCAN: begin
                if (r_idx == r_fill) begin
                    if (w_out_free) begin
                        n_m_tvalid  = 1'b1;
                        n_out_rec   = '0;
                        n_out_stat  = ST_DONE;
                        n_out_tally = TALLY_W'(r_count);
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (!w_hit || w_out_free) begin
                    w_cmd.rot = 1'b1;
                    n_idx     = r_idx + FILL_W'(1);
                    if (w_hit) begin
                        n_m_tvalid  = 1'b1;
                        n_out_rec   = w_rec[0];
                        n_out_stat  = ST_RECORD;
                        n_out_tally = '0;
                        n_out_last  = 1'b0;
                        n_count     = r_count + FILL_W'(1);
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_new       <= n_new;
        r_out_rec   <= n_out_rec;
        r_out_stat  <= n_out_stat;
        r_out_tally <= n_out_tally;
        r_out_last  <= n_out_last;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {3'b000, r_out_tally, r_out_rec.phone, r_out_rec.age,
                         r_out_rec.key.tail, r_out_rec.key.head};
    assign o_m_tuser  = r_out_stat;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Occupancy never exceeds the row
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // Occupied cells match the fill count
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("valid cells disagree with fill count");

    // A final transaction carries no record
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid && r_out_last |-> (r_out_rec == '0) && (r_out_stat != ST_RECORD))
        else $error("final transaction carries record data");

    // A record transaction is never marked last
    a_rec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid && (r_out_stat == ST_RECORD) |-> !r_out_last && (r_out_tally == '0))
        else $error("record transaction marked last");
`endif

endmodule
